[hw/rtl/weighted_route_table_lookup_assert.svh]
// assertion macros for the weighted route table lookup
`ifndef WEIGHTED_ROUTE_TABLE_LOOKUP_ASSERT_SVH
`define WEIGHTED_ROUTE_TABLE_LOOKUP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WRTL_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define WRTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wrtl_pkg.sv]
// shared types and constants for the weighted route table lookup
package wrtl_pkg;

  localparam int NUM_VNETS_DEF = 4;
  localparam int NUM_LINKS_DEF = 16;
  localparam int DEST_BITS_DEF = 64;

  localparam int WEIGHT_W = 8;
  localparam int CNT_W    = 7;
  localparam int LINK_W   = 6;
  localparam int LFSR_W   = 16;

  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

  typedef enum logic [1:0] {
    FUNC_ROUTE  = 2'd0,
    FUNC_WEIGHT = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_e;

  typedef enum logic {
    REG_ORDERED = 1'b0,
    REG_SEED    = 1'b1
  } cfg_reg_e;

  // running result handed from cell to cell
  typedef struct packed {
    logic                found;
    logic [WEIGHT_W-1:0] min_w;
    logic [CNT_W-1:0]    cnt;
    logic                hit;
    logic [LINK_W-1:0]   sel;
  } wave_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic                wr_route;
    logic                wr_weight;
    logic                sel_pass;
    logic [1:0]          vnet;
    logic [3:0]          link;
    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] min_w;
    logic [CNT_W-1:0]    pick;
  } bcast_t;

endpackage

[hw/rtl/wrtl_cell.sv]
// one link cell: route masks and weight of a link, one step of the scan wave
module wrtl_cell import wrtl_pkg::*; #(
  parameter int NUM_VNETS = NUM_VNETS_DEF,
  parameter int DEST_BITS = DEST_BITS_DEF,
  parameter int CELL_ID   = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bcast_t               bc_i,
  input  logic [DEST_BITS-1:0] dest_i,
  input  wave_t                wave_i,
  output wave_t                wave_o
);

  localparam int VIW = (NUM_VNETS > 1) ? $clog2(NUM_VNETS) : 1;

  logic [DEST_BITS-1:0] mask_q [NUM_VNETS];
  logic [NUM_VNETS-1:0] valid_q;
  logic [WEIGHT_W-1:0]  weight_q;
  wave_t                wave_q, wave_d;
  logic [VIW-1:0]       vidx;
  logic                 here, match, cand;

  assign vidx  = VIW'(bc_i.vnet);
  assign here  = (32'(bc_i.link) == 32'(CELL_ID));
  assign match = valid_q[vidx] && (|(mask_q[vidx] & dest_i));
  assign cand  = match && (weight_q == bc_i.min_w);

  always_ff @(posedge clk_i) begin
    if (bc_i.wr_route && here) begin
      mask_q[vidx] <= dest_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      weight_q <= '0;
      wave_q   <= '0;
    end else begin
      if (bc_i.wr_route && here) begin
        valid_q[vidx] <= 1'b1;
      end
      if (bc_i.wr_weight && here) begin
        weight_q <= bc_i.weight;
      end
      wave_q <= wave_d;
    end
  end

  always_comb begin
    wave_d = wave_i;
    if (!bc_i.sel_pass) begin
      // minimum weight and number of links that carry it
      if (match) begin
        if (!wave_i.found || (weight_q < wave_i.min_w)) begin
          wave_d.found = 1'b1;
          wave_d.min_w = weight_q;
          wave_d.cnt   = CNT_W'(1);
        end else if (weight_q == wave_i.min_w) begin
          wave_d.cnt = wave_i.cnt + CNT_W'(1);
        end
      end
    end else begin
      // select the candidate at position pick
      if (cand && !wave_i.hit) begin
        if (wave_i.cnt == bc_i.pick) begin
          wave_d.hit = 1'b1;
          wave_d.sel = LINK_W'(CELL_ID);
        end else begin
          wave_d.cnt = wave_i.cnt + CNT_W'(1);
        end
      end
    end
  end

  assign wave_o = wave_q;

endmodule

[hw/rtl/wrtl_rem.sv]
// restoring remainder unit, one dividend bit a cycle
module wrtl_rem import wrtl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LFSR_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [CNT_W-1:0]  rem_o
);

  localparam int STEP_W = $clog2(LFSR_W + 1);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [LFSR_W-1:0] quo_q;
  logic [CNT_W-1:0]  rem_q, div_q;
  logic [CNT_W:0]    trial;
  logic              fin;

  assign fin   = (step_q == STEP_W'(LFSR_W));
  assign trial = {rem_q, quo_q[LFSR_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (fin) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q && !fin) begin
      quo_q <= {quo_q[LFSR_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_q <= CNT_W'(trial - {1'b0, div_q});
      end else begin
        rem_q <= CNT_W'(trial);
      end
    end
  end

  assign done_o = busy_q && fin;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/weighted_route_table_lookup.sv]
// weighted route table lookup: control, tie-break lfsr and the link cell chain
// A write item (route mask or link weight) goes from the done state to the
// output register. A lookup runs a wave down the chain of link cells, one
// cell a cycle, to find the minimum weight among matching links and how many
// share it; an unordered vnet then takes the tie-break LFSR modulo that count
// in a bit-serial remainder unit, and a second wave picks the chosen link.
// One item is in flight at a time and a new one is taken while the last
// result still waits on the output.
`include "weighted_route_table_lookup_assert.svh"

module weighted_route_table_lookup import wrtl_pkg::*; #(
  parameter int NUM_VNETS = NUM_VNETS_DEF,
  parameter int NUM_LINKS = NUM_LINKS_DEF,
  parameter int DEST_BITS = DEST_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // vnet[1:0], link[5:2], dest_mask[69:6], weight[77:70], zero fill
  input  logic [79:0] s_axis_tdata,
  // func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_link[3:0], zero fill
  output logic [7:0]  m_axis_tdata,
  // no_route
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int WCW = $clog2(NUM_LINKS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_PICK = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [1:0]           vnet_q;
  logic [DEST_BITS-1:0] dest_q;
  logic [WCW-1:0]       wcnt_q, wcnt_d;
  logic [WEIGHT_W-1:0]  min_q, min_d;
  logic [CNT_W-1:0]     pick_q, pick_d;
  logic [3:0]           res_link_q, res_link_d;
  logic                 res_nr_q, res_nr_d;
  logic [3:0]           out_link_q;
  logic                 out_nr_q, m_valid_q;
  logic [3:0]           ordered_q;
  logic [LFSR_W-1:0]    lfsr_q;

  logic [1:0]           in_func, in_vnet;
  logic [3:0]           in_link;
  logic [63:0]          in_dest;
  logic [WEIGHT_W-1:0]  in_weight;
  logic                 in_acc, vnet_ok, cfg_acc, wave_end, div_start, div_done, out_load;
  logic                 pick_end, lookup_acc, nr_out;
  logic [CNT_W-1:0]     div_rem;
  bcast_t               bc;
  logic [DEST_BITS-1:0] dest_bus;
  wave_t                wave [NUM_LINKS+1];

  assign in_vnet   = s_axis_tdata[1:0];
  assign in_link   = s_axis_tdata[5:2];
  assign in_dest   = s_axis_tdata[69:6];
  assign in_weight = s_axis_tdata[77:70];
  assign in_func   = s_axis_tuser;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign vnet_ok       = (32'(in_vnet) < 32'(NUM_VNETS));
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign wave_end      = (wcnt_q == WCW'(NUM_LINKS));
  assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    bc.wr_route  = in_acc && (in_func == FUNC_ROUTE) && vnet_ok;
    bc.wr_weight = in_acc && (in_func == FUNC_WEIGHT);
    bc.sel_pass  = (state_q == ST_PICK);
    bc.vnet      = (state_q == ST_IDLE) ? in_vnet : vnet_q;
    bc.link      = in_link;
    bc.weight    = in_weight;
    bc.min_w     = min_q;
    bc.pick      = pick_q;
  end

  assign dest_bus = (state_q == ST_IDLE) ? in_dest[DEST_BITS-1:0] : dest_q;

  // link cell chain
  assign wave[0] = '0;
  for (genvar g = 0; g < NUM_LINKS; g++) begin : g_cell
    wrtl_cell #(
      .NUM_VNETS (NUM_VNETS),
      .DEST_BITS (DEST_BITS),
      .CELL_ID   (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .bc_i   (bc),
      .dest_i (dest_bus),
      .wave_i (wave[g]),
      .wave_o (wave[g+1])
    );
  end

  assign div_start = (state_q == ST_SCAN) && wave_end && wave[NUM_LINKS].found &&
                     !ordered_q[vnet_q];

  wrtl_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lfsr_q),
    .divisor_i  (wave[NUM_LINKS].cnt),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d    = state_q;
    wcnt_d     = wcnt_q;
    min_d      = min_q;
    pick_d     = pick_q;
    res_link_d = res_link_q;
    res_nr_d   = res_nr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wcnt_d     = '0;
          res_link_d = '0;
          res_nr_d   = 1'b0;
          if ((in_func == FUNC_LOOKUP) && vnet_ok) begin
            state_d = ST_SCAN;
          end else begin
            res_nr_d = (in_func == FUNC_LOOKUP);
            state_d  = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        wcnt_d = wcnt_q + WCW'(1);
        if (wave_end) begin
          wcnt_d = '0;
          min_d  = wave[NUM_LINKS].min_w;
          pick_d = '0;
          if (!wave[NUM_LINKS].found) begin
            res_nr_d = 1'b1;
            state_d  = ST_DONE;
          end else if (ordered_q[vnet_q]) begin
            state_d = ST_PICK;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          pick_d  = div_rem;
          wcnt_d  = '0;
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        wcnt_d = wcnt_q + WCW'(1);
        if (wave_end) begin
          res_link_d = wave[NUM_LINKS].sel[3:0];
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wcnt_q    <= '0;
      m_valid_q <= 1'b0;
      ordered_q <= '0;
      lfsr_q    <= SEED_RESET;
    end else begin
      state_q <= state_d;
      wcnt_q  <= wcnt_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_ORDERED: ordered_q <= cfg_data_i[3:0];
          REG_SEED:    lfsr_q    <= (cfg_data_i == '0) ? LFSR_W'(1) : cfg_data_i;
          default:     ;
        endcase
      end else if ((state_q == ST_DIV) && div_done) begin
        lfsr_q <= {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vnet_q <= in_vnet;
      dest_q <= in_dest[DEST_BITS-1:0];
    end
    min_q      <= min_d;
    pick_q     <= pick_d;
    res_link_q <= res_link_d;
    res_nr_q   <= res_nr_d;
    if (out_load) begin
      out_link_q <= res_link_q;
      out_nr_q   <= res_nr_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, out_link_q};
  assign m_axis_tuser  = out_nr_q;

  assign pick_end   = (state_q == ST_PICK) && wave_end;
  assign lookup_acc = in_acc && (in_func == FUNC_LOOKUP) && vnet_ok;
  assign nr_out     = m_axis_tvalid && m_axis_tuser;

  `WRTL_ASSERT(lfsr_nonzero, 1'b1, lfsr_q != '0, "tie-break lfsr reached zero")
  `WRTL_ASSERT(pick_hits, pick_end, wave[NUM_LINKS].hit, "pick wave found no candidate")
  `WRTL_ASSERT(no_route_zero_link, nr_out, m_axis_tdata == '0, "no_route item with nonzero link")
  `WRTL_ASSERT_NEXT(lookup_scans, lookup_acc, state_q == ST_SCAN, "lookup did not start a scan")

endmodule
